// File: rtl/rmtc_pkg.sv
// Package with the shared constants, types and axis helper of the ray-march transition counter.
`default_nettype none

package rmtc_pkg;

  localparam int VOXEL_DEPTH = 262144;
  localparam int MAX_STEPS   = 512;
  localparam int FRAC_BITS   = 12;
  localparam int DIR_BITS    = 14;

  localparam int DIM_W   = 7;
  localparam int SL_W    = 14;
  localparam int ENTRY_W = 21;
  localparam int DIR_W   = 16;
  localparam int SCNT_W  = 10;
  localparam int COUNT_W = 10;
  localparam int VIDX_W  = 18;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam int ADDR_W  = $clog2(VOXEL_DEPTH);
  localparam int IDX_W   = (ADDR_W + 1 > 3 * DIM_W) ? ADDR_W + 1 : 3 * DIM_W;
  localparam int CNT_W   = $clog2(MAX_STEPS + 1);
  localparam int DIST_W  = SL_W + CNT_W;
  localparam int WH_W    = 2 * DIM_W;
  localparam int MA_W    = DIR_W + 1;
  localparam int MB_W    = (DIST_W > WH_W) ? DIST_W : WH_W;
  localparam int MP_W    = MA_W + MB_W + 1;
  localparam int POS_W   = MP_W - DIR_BITS + 1;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LENGTH = 2'd2,
    REG_STEP   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] l;
    logic [SL_W-1:0]  sl;
  } cfg_t;

  typedef struct packed {
    logic signed [MA_W-1:0] a;
    logic [MB_W-1:0]        b;
    logic signed [MP_W-1:0] c;
  } mac_cmd_t;

  typedef struct packed {
    logic             inr;
    logic [DIM_W-1:0] vox;
  } axis_t;

  function automatic axis_t axis_cell(input logic signed [MP_W-1:0] prod,
                                      input logic signed [ENTRY_W-1:0] entry,
                                      input logic [DIM_W-1:0] dim);
    logic signed [POS_W-1:0]       pos;
    logic signed [POS_W-1:0]       lim;
    logic [DIM_W+FRAC_BITS:0]      rsum;
    logic [DIM_W:0]                r;
    axis_t                         res;
    pos  = POS_W'(prod >>> DIR_BITS) + POS_W'(entry);
    lim  = '0;
    lim[FRAC_BITS +: DIM_W] = dim;
    res.inr = !pos[POS_W-1] && (pos < lim);
    rsum = (DIM_W + FRAC_BITS + 1)'(pos[DIM_W+FRAC_BITS-1:0])
         + (DIM_W + FRAC_BITS + 1)'(1 << (FRAC_BITS - 1));
    r    = rsum[DIM_W+FRAC_BITS:FRAC_BITS];
    if (r >= (DIM_W + 1)'(dim)) begin
      res.vox = dim - DIM_W'(1);
    end else begin
      res.vox = r[DIM_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rmtc_mac.sv
// Shared registered multiply-add unit used for positions and voxel addresses.
`default_nettype none

module rmtc_mac (
  input  wire logic                              clk,
  input  wire rmtc_pkg::mac_cmd_t                cmd,
  output logic signed [rmtc_pkg::MP_W-1:0]       res
);
  import rmtc_pkg::*;

  logic signed [MA_W-1:0] a_s;
  logic signed [MB_W:0]   b_s;
  logic signed [MP_W-1:0] c_s;
  logic signed [MP_W-1:0] prod;
  logic signed [MP_W-1:0] res_r;

  assign a_s  = cmd.a;
  assign b_s  = signed'({1'b0, cmd.b});
  assign c_s  = cmd.c;
  assign prod = a_s * b_s;

  always_ff @(posedge clk) begin
    res_r <= prod + c_s;
  end

  assign res = res_r;

endmodule

`default_nettype wire

// File: rtl/rmtc_vmem.sv
// One-bit voxel memory with a write port and a registered read port.
`default_nettype none

module rmtc_vmem (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [rmtc_pkg::ADDR_W-1:0]   waddr,
  input  wire logic                          wdata,
  input  wire logic                          re,
  input  wire logic [rmtc_pkg::ADDR_W-1:0]   raddr,
  output logic                               rdata
);
  import rmtc_pkg::*;

  logic mem [VOXEL_DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/rmtc_seq.sv
// Sequencer that marches one ray sample at a time through the shared unit and memory.
`default_nettype none

module rmtc_seq (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire rmtc_pkg::cfg_t                        cfg,
  input  wire logic                                  start,
  input  wire logic                                  in_op,
  input  wire logic signed [rmtc_pkg::ENTRY_W-1:0]   in_entry_x,
  input  wire logic signed [rmtc_pkg::ENTRY_W-1:0]   in_entry_y,
  input  wire logic signed [rmtc_pkg::ENTRY_W-1:0]   in_entry_z,
  input  wire logic signed [rmtc_pkg::DIR_W-1:0]     in_dir_x,
  input  wire logic signed [rmtc_pkg::DIR_W-1:0]     in_dir_y,
  input  wire logic signed [rmtc_pkg::DIR_W-1:0]     in_dir_z,
  input  wire logic [rmtc_pkg::SCNT_W-1:0]           in_step_count,
  output logic                                       busy,
  output logic                                       out_valid,
  output logic [rmtc_pkg::COUNT_W-1:0]               out_crossing_count,
  output rmtc_pkg::mac_cmd_t                         mac_cmd,
  input  wire logic signed [rmtc_pkg::MP_W-1:0]      mac_res,
  output logic                                       mem_re,
  output logic [rmtc_pkg::ADDR_W-1:0]                mem_raddr,
  input  wire logic                                  mem_rdata
);
  import rmtc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_WH   = 9'b000000010,
    S_MX   = 9'b000000100,
    S_MY   = 9'b000001000,
    S_MZ   = 9'b000010000,
    S_CZ   = 9'b000100000,
    S_IY   = 9'b001000000,
    S_RD   = 9'b010000000,
    S_UPD  = 9'b100000000
  } state_t;

  state_t                     state_r, state_nxt;
  logic signed [ENTRY_W-1:0]  ex_r, ex_nxt, ey_r, ey_nxt, ez_r, ez_nxt;
  logic signed [DIR_W-1:0]    dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt, i_r, i_nxt;
  logic [CNT_W-1:0]           cnt_clamp;
  logic [DIST_W-1:0]          dist_r, dist_nxt;
  logic [WH_W-1:0]            wh_r, wh_nxt;
  axis_t                      cx_r, cx_nxt, cy_r, cy_nxt, cz;
  logic                       inr_r, inr_nxt;
  logic                       ok_r, ok_nxt;
  logic                       prev_r, prev_nxt;
  logic [COUNT_W-1:0]         tot_r, tot_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]         out_count_r, out_count_nxt;
  logic                       cur_bone;

  assign cz        = axis_cell(mac_res, ez_r, cfg.l);
  assign cur_bone  = ok_r & mem_rdata;
  assign mem_raddr = mac_res[ADDR_W-1:0];
  assign cnt_clamp = (32'(in_step_count) > 32'(MAX_STEPS)) ? CNT_W'(MAX_STEPS)
                                                           : CNT_W'(in_step_count);

  always_comb begin
    state_nxt     = state_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    ez_nxt        = ez_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    dz_nxt        = dz_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    dist_nxt      = dist_r;
    wh_nxt        = wh_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    inr_nxt       = inr_r;
    ok_nxt        = ok_r;
    prev_nxt      = prev_r;
    tot_nxt       = tot_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    mac_cmd       = '0;
    mem_re        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start && in_op) begin
          ex_nxt   = in_entry_x;
          ey_nxt   = in_entry_y;
          ez_nxt   = in_entry_z;
          dx_nxt   = in_dir_x;
          dy_nxt   = in_dir_y;
          dz_nxt   = in_dir_z;
          cnt_nxt  = cnt_clamp;
          i_nxt    = '0;
          dist_nxt = '0;
          tot_nxt  = '0;
          prev_nxt = 1'b0;
          if (cnt_clamp == '0) begin
            out_valid_nxt = 1'b1;
            out_count_nxt = COUNT_W'(1);
          end else begin
            state_nxt = S_WH;
          end
        end
      end
      S_WH: begin
        mac_cmd.a = MA_W'(cfg.w);
        mac_cmd.b = MB_W'(cfg.h);
        state_nxt = S_MX;
      end
      S_MX: begin
        if (i_r == '0) begin
          wh_nxt = mac_res[WH_W-1:0];
        end
        mac_cmd.a = MA_W'(dx_r);
        mac_cmd.b = MB_W'(dist_r);
        state_nxt = S_MY;
      end
      S_MY: begin
        cx_nxt    = axis_cell(mac_res, ex_r, cfg.w);
        mac_cmd.a = MA_W'(dy_r);
        mac_cmd.b = MB_W'(dist_r);
        state_nxt = S_MZ;
      end
      S_MZ: begin
        cy_nxt    = axis_cell(mac_res, ey_r, cfg.h);
        mac_cmd.a = MA_W'(dz_r);
        mac_cmd.b = MB_W'(dist_r);
        state_nxt = S_CZ;
      end
      S_CZ: begin
        inr_nxt   = cx_r.inr & cy_r.inr & cz.inr;
        mac_cmd.a = MA_W'(cz.vox);
        mac_cmd.b = MB_W'(wh_r);
        mac_cmd.c = MP_W'(cx_r.vox);
        state_nxt = S_IY;
      end
      S_IY: begin
        mac_cmd.a = MA_W'(cy_r.vox);
        mac_cmd.b = MB_W'(cfg.w);
        mac_cmd.c = mac_res;
        state_nxt = S_RD;
      end
      S_RD: begin
        mem_re    = 1'b1;
        ok_nxt    = inr_r && (mac_res[IDX_W-1:0] < IDX_W'(VOXEL_DEPTH));
        state_nxt = S_UPD;
      end
      S_UPD: begin
        prev_nxt = cur_bone;
        if ((i_r != '0) && (cur_bone != prev_r) && (tot_r != '1)) begin
          tot_nxt = tot_r + COUNT_W'(1);
        end
        if (i_r == cnt_r) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = (tot_nxt == '0) ? COUNT_W'(1) : tot_nxt;
          state_nxt     = S_IDLE;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          dist_nxt  = dist_r + DIST_W'(cfg.sl);
          state_nxt = S_MX;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      prev_r      <= 1'b0;
      tot_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      prev_r      <= prev_nxt;
      tot_r       <= tot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ex_r        <= ex_nxt;
    ey_r        <= ey_nxt;
    ez_r        <= ez_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    dz_r        <= dz_nxt;
    cnt_r       <= cnt_nxt;
    dist_r      <= dist_nxt;
    wh_r        <= wh_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    inr_r       <= inr_nxt;
    ok_r        <= ok_nxt;
    out_count_r <= out_count_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_crossing_count = out_count_r;

endmodule

`default_nettype wire

// File: rtl/ray_march_transition_counter.sv
// Top level of the ray-march transition counter with its register port.
//
// An item is transferred when start is high and busy is low. With in_op low it
// writes in_voxel_bit to the voxel at in_voxel_index in that same cycle, gives
// no result and leaves busy low, so the next item may follow at once.
// With in_op high it marches a ray and busy stays high until it is done.
// Each ray gives one result: out_valid is high for exactly one cycle with
// out_crossing_count, and the receiver cannot stall it.
// A ray with a step count of zero gives its result in the cycle after its
// transfer. A ray of n steps, n clamped to 512, marches n + 1 samples: one
// state forms the plane size on the shared multiply-add unit, then every
// sample takes five issues to that unit, one read of the voxel memory and
// one update of the count. The next item is taken in the cycle that shows
// the result. Registers must be written through the APB port while the block
// is idle; the block itself does not enforce this.
// Reset clears the sequencer and returns the registers to a 64 voxel cube
// with half a voxel of step; the voxel memory is not cleared and each voxel
// must be written before a ray reads it.
`default_nettype none

module ray_march_transition_counter (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic                                  in_op,
  input  wire logic [rmtc_pkg::VIDX_W-1:0]           in_voxel_index,
  input  wire logic                                  in_voxel_bit,
  input  wire logic signed [rmtc_pkg::ENTRY_W-1:0]   in_entry_x,
  input  wire logic signed [rmtc_pkg::ENTRY_W-1:0]   in_entry_y,
  input  wire logic signed [rmtc_pkg::ENTRY_W-1:0]   in_entry_z,
  input  wire logic signed [rmtc_pkg::DIR_W-1:0]     in_dir_x,
  input  wire logic signed [rmtc_pkg::DIR_W-1:0]     in_dir_y,
  input  wire logic signed [rmtc_pkg::DIR_W-1:0]     in_dir_z,
  input  wire logic [rmtc_pkg::SCNT_W-1:0]           in_step_count,
  output logic                                       out_valid,
  output logic [rmtc_pkg::COUNT_W-1:0]               out_crossing_count,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [rmtc_pkg::PADDR_W-1:0]          paddr,
  input  wire logic [rmtc_pkg::PDATA_W-1:0]          pwdata,
  output logic [rmtc_pkg::PDATA_W-1:0]               prdata,
  output logic                                       pready
);
  import rmtc_pkg::*;

  logic [DIM_W-1:0] width_r, height_r, length_r;
  logic [SL_W-1:0]  step_r;
  cfg_t             cfg;
  reg_idx_t         reg_sel;
  logic             cfg_we;
  mac_cmd_t         mac_cmd;
  logic signed [MP_W-1:0] mac_res;
  logic             mem_we;
  logic             mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic             mem_rdata;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(64);
      height_r <= DIM_W'(64);
      length_r <= DIM_W'(64);
      step_r   <= SL_W'(2048);
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        REG_LENGTH: length_r <= pwdata[DIM_W-1:0];
        REG_STEP:   step_r   <= pwdata[SL_W-1:0];
        default:    width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = PDATA_W'(width_r);
      REG_HEIGHT: prdata = PDATA_W'(height_r);
      REG_LENGTH: prdata = PDATA_W'(length_r);
      REG_STEP:   prdata = PDATA_W'(step_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg.w  = width_r;
  assign cfg.h  = height_r;
  assign cfg.l  = length_r;
  assign cfg.sl = step_r;

  assign mem_we = start && !busy && !in_op
               && (IDX_W'(in_voxel_index) < IDX_W'(VOXEL_DEPTH));

  rmtc_vmem u_vmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (in_voxel_index[ADDR_W-1:0]),
    .wdata (in_voxel_bit),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rmtc_mac u_mac (
    .clk (clk),
    .cmd (mac_cmd),
    .res (mac_res)
  );

  rmtc_seq u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .start              (start),
    .in_op              (in_op),
    .in_entry_x         (in_entry_x),
    .in_entry_y         (in_entry_y),
    .in_entry_z         (in_entry_z),
    .in_dir_x           (in_dir_x),
    .in_dir_y           (in_dir_y),
    .in_dir_z           (in_dir_z),
    .in_step_count      (in_step_count),
    .busy               (busy),
    .out_valid          (out_valid),
    .out_crossing_count (out_crossing_count),
    .mac_cmd            (mac_cmd),
    .mac_res            (mac_res),
    .mem_re             (mem_re),
    .mem_raddr          (mem_raddr),
    .mem_rdata          (mem_rdata)
  );

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a ray is still in progress");

  a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_crossing_count != '0))
    else $error("crossing count of zero reported");

  a_empty_ray: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op && (in_step_count == '0)) |=> (out_valid && !busy))
    else $error("ray without steps did not finish at once");

  a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_op) |=> (!busy && !out_valid))
    else $error("voxel write transfer started a ray or gave a result");

endmodule

`default_nettype wire
